// ===== rtl/core/id3v2_frame_walker_core_assert.svh =====
// Assertion macros used by the frame walker checker.
// Needs signals named clock and reset in the including scope.
`ifndef ID3V2_FRAME_WALKER_CORE_ASSERT_SVH
`define ID3V2_FRAME_WALKER_CORE_ASSERT_SVH

// Same-cycle implication, muted during reset
`define FW_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("id3fw check failed");

// Next-cycle implication, muted during reset
`define FW_ASSERT_NXT_D(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("id3fw check failed");

// Next-cycle implication, live through reset
`define FW_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("id3fw check failed");

`endif

// ===== rtl/core/id3fw_pkg.sv =====
// Types, constants and helper functions of the ID3v2 frame walker.
// No dependencies.
`timescale 1ns / 1ps
package id3fw_pkg;

   localparam int OFFSET_BITS    = 28;
   localparam int MIME_MAX_CHARS = 10;
   localparam int LEN_W          = 32;
   localparam int CNT_W          = $clog2(MIME_MAX_CHARS + 1);
   localparam int SKIP_W         = ((OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W) + 2;
   localparam int MIME_N         = 6;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAJOR_VERSION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXT_HEADER    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACQUIRE_IMAGE = 2'd2;

   localparam logic [2:0] VERSION_SYNCHSAFE = 3'd4;

   localparam logic [1:0] STAT_EXHAUSTED = 2'd0;
   localparam logic [1:0] STAT_PADDING   = 2'd1;
   localparam logic [1:0] STAT_BAD_ENC   = 2'd2;

   localparam logic [7:0] ENC_LATIN1 = 8'd0;
   localparam logic [7:0] ENC_UTF8   = 8'd3;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   localparam logic [31:0] NM_APIC = "APIC";
   localparam logic [31:0] NM_TIT2 = "TIT2";
   localparam logic [31:0] NM_TALB = "TALB";
   localparam logic [31:0] NM_TPE1 = "TPE1";
   localparam logic [31:0] NM_TRCK = "TRCK";
   localparam logic [31:0] NM_TYER = "TYER";
   localparam logic [31:0] NM_TDRC = "TDRC";

   localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

   typedef enum logic [2:0] {
      KIND_TITLE  = 3'd0,
      KIND_ALBUM  = 3'd1,
      KIND_ARTIST = 3'd2,
      KIND_TRACK  = 3'd3,
      KIND_YEAR   = 3'd4,
      KIND_IMAGE  = 3'd5,
      KIND_END    = 3'd6
   } kind_type;

   typedef enum logic [9:0] {
      PH_IDLE  = 10'b00_0000_0001,
      PH_EXT   = 10'b00_0000_0010,
      PH_HDR   = 10'b00_0000_0100,
      PH_ENC   = 10'b00_0000_1000,
      PH_TRACK = 10'b00_0001_0000,
      PH_MIME  = 10'b00_0010_0000,
      PH_PTYPE = 10'b00_0100_0000,
      PH_DESC  = 10'b00_1000_0000,
      PH_SKIP  = 10'b01_0000_0000,
      PH_STOP  = 10'b10_0000_0000
   } phase_type;

   typedef struct packed {
      logic [2:0] major_version;
      logic       extended_header_present;
      logic       acquire_image;
   } cfg_type;

   typedef struct packed {
      kind_type               item_kind;
      logic [OFFSET_BITS-1:0] payload_offset;
      logic [LEN_W-1:0]       payload_length;
      logic                   text_encoding;
      logic                   picture_format;
      logic [1:0]             end_status;
      logic                   last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   // v4 sizes are synchsafe, low byte upward, stopping at a byte with bit 7 set
   function automatic logic [LEN_W-1:0] decode_size(input logic [31:0] raw,
                                                    input logic [2:0] major);
      logic [LEN_W-1:0] size;
      logic             done;
      size = '0;
      done = 1'b0;
      if (major != VERSION_SYNCHSAFE) begin
         size = raw;
      end else begin
         for (int k = 0; k < 4; k++) begin
            if (raw[8*k+7]) done = 1'b1;
            if (!done) size = size | (LEN_W'(raw[8*k +: 7]) << (7 * k));
         end
      end
      return size;
   endfunction

   function automatic logic [OFFSET_BITS-1:0] sat_pos(input logic [SKIP_W-1:0] v);
      return (v > SKIP_W'(POS_MAX)) ? POS_MAX : v[OFFSET_BITS-1:0];
   endfunction

   function automatic logic [SKIP_W-1:0] clamp_len(input logic [SKIP_W-1:0] a,
                                                   input logic [SKIP_W-1:0] b);
      return (a > b) ? (a - b) : '0;
   endfunction

   function automatic logic is_text(input logic [31:0] nm);
      return (nm == NM_TIT2) || (nm == NM_TALB) || (nm == NM_TPE1) ||
             (nm == NM_TRCK) || (nm == NM_TYER) || (nm == NM_TDRC);
   endfunction

   function automatic kind_type text_code(input logic [31:0] nm);
      kind_type k;
      k = KIND_YEAR;
      if (nm == NM_TIT2) k = KIND_TITLE;
      else if (nm == NM_TALB) k = KIND_ALBUM;
      else if (nm == NM_TPE1) k = KIND_ARTIST;
      else if (nm == NM_TRCK) k = KIND_TRACK;
      return k;
   endfunction

   // MIME candidates: png, image/png, jpeg, image/jpeg, jpg, image/jpg
   function automatic logic [4:0] mime_len(input int k);
      logic [4:0] l;
      case (k)
         0: l = 5'd3;
         1: l = 5'd9;
         2: l = 5'd4;
         3: l = 5'd10;
         4: l = 5'd3;
         default: l = 5'd9;
      endcase
      return l;
   endfunction

   function automatic logic mime_fmt(input int k);
      return (k < 2);
   endfunction

   function automatic logic [7:0] mime_char(input int k, input logic [CNT_W-1:0] idx);
      logic [79:0] s;
      int          l;
      logic [7:0]  ch;
      case (k)
         0: s = 80'("png");
         1: s = 80'("image/png");
         2: s = 80'("jpeg");
         3: s = 80'("image/jpeg");
         4: s = 80'("jpg");
         default: s = 80'("image/jpg");
      endcase
      l  = int'(mime_len(k));
      ch = 8'h00;
      if (int'(idx) < l) ch = s[8*(l-1-int'(idx)) +: 8];
      return ch;
   endfunction

endpackage

// ===== rtl/core/id3fw_if.sv =====
// Handshake channels of the frame walker: body bytes in, results out.
// Depends on id3fw_pkg.
`timescale 1ns / 1ps
interface id3fw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, data_byte, last_byte, input ready);
   modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface id3fw_rsp_if;
   import id3fw_pkg::*;
   logic                   valid;
   logic                   ready;
   kind_type               item_kind;
   logic [OFFSET_BITS-1:0] payload_offset;
   logic [LEN_W-1:0]       payload_length;
   logic                   text_encoding;
   logic                   picture_format;
   logic [1:0]             end_status;
   logic                   last_of_run;
   modport source (output valid, item_kind, payload_offset, payload_length,
                   text_encoding, picture_format, end_status, last_of_run,
                   input ready);
   modport sink (input valid, item_kind, payload_offset, payload_length,
                 text_encoding, picture_format, end_status, last_of_run,
                 output ready);
endinterface

// ===== rtl/core/id3fw_parse.sv =====
// Parser state and per-byte next-state logic; emits up to two results a beat.
// Depends on id3fw_pkg.
`timescale 1ns / 1ps
module id3fw_parse (
   input  logic                clock,
   input  logic                reset,
   input  id3fw_pkg::cfg_type  cfg,
   input  logic                fire,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   output id3fw_pkg::push_type push
);
   import id3fw_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] fs_ff, fs_in;
   logic [SKIP_W-1:0]      skip_ff, skip_in;
   logic [31:0]            name_ff, name_in;
   logic [31:0]            flen_ff, flen_in;
   logic [7:0]             enc_ff, enc_in;
   logic [MIME_N-1:0]      alive_ff, alive_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   held_ff, held_in;
   logic                   stop_ff, stop_in;

   rsp_type                slot [2];
   logic [1:0]             n_out;

   function automatic rsp_type make_rsp(input kind_type k, input logic [SKIP_W-1:0] off,
                                        input logic [SKIP_W-1:0] len, input logic enc,
                                        input logic held, input logic [1:0] status);
      rsp_type r;
      r.item_kind      = k;
      r.payload_offset = sat_pos(off);
      r.payload_length = len[LEN_W-1:0];
      r.text_encoding  = enc;
      r.picture_format = held;
      r.end_status     = status;
      r.last_of_run    = 1'b0;
      return r;
   endfunction

   // Work out the next state and results for the byte on the input
   always_comb begin
      logic [SKIP_W-1:0]      pw, qw, fsw, off;
      logic [OFFSET_BITS-1:0] idx;
      logic                   enc_bit;
      logic                   found;
      pw      = SKIP_W'(pos_ff);
      qw      = pw + SKIP_W'(1);
      enc_bit = (enc_ff == ENC_UTF8);
      found   = 1'b0;
      off     = '0;
      idx     = '0;

      phase_in = phase_ff;
      pos_in   = pos_ff;
      fs_in    = fs_ff;
      skip_in  = skip_ff;
      name_in  = name_ff;
      flen_in  = flen_ff;
      enc_in   = enc_ff;
      alive_in = alive_ff;
      cnt_in   = cnt_ff;
      held_in  = held_ff;
      stop_in  = stop_ff;
      slot[0]  = '0;
      slot[1]  = '0;
      n_out    = 2'd0;

      // pick extended header or first frame header
      if (phase_ff == PH_IDLE) begin
         if (cfg.extended_header_present) begin
            phase_in = PH_EXT;
            flen_in  = '0;
         end else begin
            phase_in = PH_HDR;
            fs_in    = pos_ff;
            name_in  = '0;
            flen_in  = '0;
         end
      end
      fsw = SKIP_W'(fs_in);

      case (phase_in)
         PH_EXT: begin
            flen_in = {flen_in[23:0], data_byte};
            if (pos_ff >= OFFSET_BITS'(3)) begin
               skip_in = SKIP_W'(decode_size(flen_in, cfg.major_version)) +
                         ((cfg.major_version != VERSION_SYNCHSAFE) ? SKIP_W'(4) : '0);
               phase_in = PH_SKIP;
            end
         end
         PH_HDR: begin
            idx = pos_ff - fs_in;
            if (idx < OFFSET_BITS'(4)) name_in = {name_in[23:0], data_byte};
            else if (idx < OFFSET_BITS'(8)) flen_in = {flen_in[23:0], data_byte};
            if (idx == OFFSET_BITS'(9)) begin
               flen_in = decode_size(flen_in, cfg.major_version);
               skip_in = fsw + SKIP_W'(10) + SKIP_W'(flen_in);
               if (name_in == '0) begin
                  slot[n_out[0]] = make_rsp(KIND_END, pw, '0, 1'b0, held_in, STAT_PADDING);
                  n_out    = n_out + 2'd1;
                  phase_in = PH_STOP;
                  stop_in  = 1'b1;
               end else if (name_in == NM_APIC) begin
                  phase_in = cfg.acquire_image ? PH_ENC : PH_SKIP;
               end else begin
                  phase_in = PH_ENC;
               end
            end
         end
         PH_ENC: begin
            enc_in = data_byte;
            if (name_in == NM_APIC) begin
               alive_in = '1;
               cnt_in   = '0;
               phase_in = PH_MIME;
            end else if (data_byte != ENC_LATIN1 && data_byte != ENC_UTF8) begin
               slot[n_out[0]] = make_rsp(KIND_END, pw, '0, 1'b0, held_in, STAT_BAD_ENC);
               n_out    = n_out + 2'd1;
               phase_in = PH_STOP;
               stop_in  = 1'b1;
            end else begin
               phase_in = PH_SKIP;
               if (is_text(name_in)) begin
                  if (text_code(name_in) == KIND_TRACK) begin
                     phase_in = PH_TRACK;
                  end else begin
                     slot[n_out[0]] = make_rsp(text_code(name_in), qw,
                        (flen_in != '0) ? SKIP_W'(flen_in - 32'd1) : '0,
                        data_byte == ENC_UTF8, held_in, STAT_EXHAUSTED);
                     n_out = n_out + 2'd1;
                  end
               end
            end
         end
         PH_TRACK: begin
            if (data_byte == CHAR_NUL || data_byte == CHAR_SLASH) begin
               slot[n_out[0]] = make_rsp(KIND_TRACK, fsw + SKIP_W'(11),
                  clamp_len(pw, fsw + SKIP_W'(11)), enc_bit, held_in, STAT_EXHAUSTED);
               n_out    = n_out + 2'd1;
               phase_in = PH_SKIP;
            end
         end
         PH_MIME: begin
            if (data_byte == CHAR_NUL) begin
               // first live candidate of exact length sets the format
               for (int k = 0; k < MIME_N; k++) begin
                  if (!found && alive_in[k] && (5'(cnt_in) == mime_len(k))) begin
                     held_in = mime_fmt(k);
                     found   = 1'b1;
                  end
               end
               phase_in = PH_PTYPE;
            end else begin
               for (int k = 0; k < MIME_N; k++) begin
                  if (!((5'(cnt_in) < mime_len(k)) &&
                        (cnt_in < CNT_W'(MIME_MAX_CHARS)) &&
                        (mime_char(k, cnt_in) == data_byte)))
                     alive_in[k] = 1'b0;
               end
               if (cnt_in < CNT_W'(MIME_MAX_CHARS)) cnt_in = cnt_in + CNT_W'(1);
               else alive_in = '0;
            end
         end
         PH_PTYPE: begin
            phase_in = PH_DESC;
         end
         PH_DESC: begin
            if (data_byte == CHAR_NUL) begin
               off = qw + ((enc_in != ENC_LATIN1 && enc_in != ENC_UTF8) ?
                           SKIP_W'(1) : '0);
               slot[n_out[0]] = make_rsp(KIND_IMAGE, off, clamp_len(skip_in, off),
                                         1'b0, held_in, STAT_EXHAUSTED);
               n_out    = n_out + 2'd1;
               phase_in = PH_SKIP;
            end
         end
         default: begin
         end
      endcase

      // close the frame when its last byte has gone by
      if ((phase_in == PH_ENC || phase_in == PH_TRACK || phase_in == PH_MIME ||
           phase_in == PH_PTYPE || phase_in == PH_DESC || phase_in == PH_SKIP) &&
          qw >= skip_in) begin
         if (phase_in == PH_ENC) begin
            if (name_in == NM_APIC) begin
               slot[n_out[0]] = make_rsp(KIND_IMAGE, skip_in, '0, 1'b0, held_in,
                                         STAT_EXHAUSTED);
               n_out = n_out + 2'd1;
            end else if (is_text(name_in)) begin
               slot[n_out[0]] = make_rsp(text_code(name_in), fsw + SKIP_W'(11), '0,
                                         1'b0, held_in, STAT_EXHAUSTED);
               n_out = n_out + 2'd1;
            end
         end else if (phase_in == PH_TRACK) begin
            slot[n_out[0]] = make_rsp(KIND_TRACK, fsw + SKIP_W'(11),
               clamp_len(skip_in, fsw + SKIP_W'(11)), enc_bit, held_in, STAT_EXHAUSTED);
            n_out = n_out + 2'd1;
         end else if (phase_in != PH_SKIP) begin
            slot[n_out[0]] = make_rsp(KIND_IMAGE, skip_in, '0, 1'b0, held_in,
                                      STAT_EXHAUSTED);
            n_out = n_out + 2'd1;
         end
         phase_in = PH_HDR;
         fs_in    = sat_pos(qw);
         name_in  = '0;
         flen_in  = '0;
      end
      pos_in = sat_pos(qw);

      // final body byte: report end unless already stopped, then clear
      if (last_byte) begin
         if (!stop_in) begin
            slot[n_out[0]] = make_rsp(KIND_END, pw, '0, 1'b0, held_in, STAT_EXHAUSTED);
            n_out = n_out + 2'd1;
         end
         phase_in = PH_IDLE;
         pos_in   = '0;
         fs_in    = '0;
         skip_in  = '0;
         name_in  = '0;
         flen_in  = '0;
         enc_in   = '0;
         alive_in = '1;
         cnt_in   = '0;
         held_in  = 1'b0;
         stop_in  = 1'b0;
      end

      // flag the final result of this beat
      if (n_out == 2'd1) slot[0].last_of_run = 1'b1;
      if (n_out == 2'd2) slot[1].last_of_run = 1'b1;
   end

   assign push.count  = fire ? n_out : 2'd0;
   assign push.first  = slot[0];
   assign push.second = slot[1];

   // Advance state on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= '0;
         fs_ff    <= '0;
         skip_ff  <= '0;
         name_ff  <= '0;
         flen_ff  <= '0;
         enc_ff   <= '0;
         alive_ff <= '1;
         cnt_ff   <= '0;
         held_ff  <= 1'b0;
         stop_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         fs_ff    <= fs_in;
         skip_ff  <= skip_in;
         name_ff  <= name_in;
         flen_ff  <= flen_in;
         enc_ff   <= enc_in;
         alive_ff <= alive_in;
         cnt_ff   <= cnt_in;
         held_ff  <= held_in;
         stop_ff  <= stop_in;
      end
   end

endmodule

// ===== rtl/core/id3fw_rsp_fifo.sv =====
// Four-entry result queue: takes up to two results a cycle, gives one.
// Depends on id3fw_pkg.
`timescale 1ns / 1ps
module id3fw_rsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  id3fw_pkg::push_type push,
   output logic                has_room,
   output logic                out_valid,
   input  logic                out_ready,
   output id3fw_pkg::rsp_type  out_data
);
   import id3fw_pkg::*;

   rsp_type    mem_ff [4];
   logic [1:0] head_ff, head_in;
   logic [1:0] tail_ff, tail_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   assign out_valid = (count_ff != 3'd0);
   assign out_data  = mem_ff[head_ff];
   assign has_room  = (count_ff <= 3'd2);
   assign pop       = out_valid && out_ready;

   // Move pointers and fill level
   always_comb begin
      head_in  = head_ff + (pop ? 2'd1 : 2'd0);
      tail_in  = tail_ff + push.count;
      count_in = count_ff + 3'(push.count) - (pop ? 3'd1 : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Write the new results behind the tail
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) mem_ff[tail_ff] <= push.first;
      if (push.count == 2'd2) mem_ff[tail_ff + 2'd1] <= push.second;
   end

endmodule

// ===== rtl/core/id3v2_frame_walker_core.sv =====
// Streaming ID3v2 frame walker: one body byte per beat, results to a queue.
// Results are queued when their byte is taken; rsp_bus shows the queue head.
// Throughput: one byte per cycle while the four-entry result queue has two
// free entries; results leave at one per cycle while rsp_bus.ready is high.
// Reset: synchronous, active high; clears parser state, queue and registers
// (major_version 3, other registers 0).
`timescale 1ns / 1ps
module id3v2_frame_walker_core (
   input  logic                               clock,
   input  logic                               reset,
   id3fw_req_if.sink                          req_bus,
   id3fw_rsp_if.source                        rsp_bus,
   input  logic                               csr_write_enable,
   input  logic [id3fw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [id3fw_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import id3fw_pkg::*;

   cfg_type  cfg_ff;
   push_type push;
   rsp_type  head;
   logic     has_room;
   logic     fire;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.major_version           <= 3'd3;
         cfg_ff.extended_header_present <= 1'b0;
         cfg_ff.acquire_image           <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MAJOR_VERSION: cfg_ff.major_version <= csr_write_data;
            CSR_EXT_HEADER:    cfg_ff.extended_header_present <= csr_write_data[0];
            CSR_ACQUIRE_IMAGE: cfg_ff.acquire_image <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   assign req_bus.ready = has_room;
   assign fire          = req_bus.valid && has_room;

   id3fw_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .fire      (fire),
      .data_byte (req_bus.data_byte),
      .last_byte (req_bus.last_byte),
      .push      (push)
   );

   id3fw_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (head)
   );

   // Drive the result beat
   assign rsp_bus.item_kind      = head.item_kind;
   assign rsp_bus.payload_offset = head.payload_offset;
   assign rsp_bus.payload_length = head.payload_length;
   assign rsp_bus.text_encoding  = head.text_encoding;
   assign rsp_bus.picture_format = head.picture_format;
   assign rsp_bus.end_status     = head.end_status;
   assign rsp_bus.last_of_run    = head.last_of_run;

endmodule

// ===== rtl/core/id3fw_checker.sv =====
// Port-level checks of the frame walker result channel, bound to the top.
// Depends on id3fw_pkg and id3v2_frame_walker_core_assert.svh.
`timescale 1ns / 1ps
`include "id3v2_frame_walker_core_assert.svh"
module id3fw_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input id3fw_pkg::kind_type                rsp_kind,
   input logic [id3fw_pkg::OFFSET_BITS-1:0]  rsp_offset,
   input logic [id3fw_pkg::LEN_W-1:0]        rsp_length,
   input logic [1:0]                         rsp_status
);
   import id3fw_pkg::*;

   `FW_ASSERT_NXT_D(rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `FW_ASSERT_NXT_D(rsp_steady, rsp_valid && !rsp_ready, $stable(rsp_kind) && $stable(rsp_offset) && $stable(rsp_length))
   `FW_ASSERT_IMP(end_len_zero, rsp_valid && rsp_kind == KIND_END, rsp_length == '0)
   `FW_ASSERT_IMP(status_on_end, rsp_valid && rsp_kind != KIND_END, rsp_status == STAT_EXHAUSTED)
   `FW_ASSERT_NXT(reset_empty, reset, !rsp_valid)

endmodule

bind id3v2_frame_walker_core id3fw_checker u_id3fw_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_kind   (rsp_bus.item_kind),
   .rsp_offset (rsp_bus.payload_offset),
   .rsp_length (rsp_bus.payload_length),
   .rsp_status (rsp_bus.end_status)
);
